// ===== design/pve_pkg.sv =====
`timescale 1ns / 1ps

package pve_pkg;

   localparam int VALUE_W      = 64;
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [1:0] {
      MODE_UNSIGNED = 2'd0,
      MODE_SIGNED   = 2'd1,
      MODE_DOUBLE   = 2'd2,
      MODE_SPARE    = 2'd3
   } mode_type;

   localparam logic [7:0] HDR_TWO   = 8'h80;
   localparam logic [7:0] HDR_THREE = 8'hC0;
   localparam logic [7:0] HDR_FOUR  = 8'hE0;
   localparam logic [7:0] HDR_LONG  = 8'hF0;

   typedef struct packed {
      logic [1:0]         action;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [3:0] byte_index;
      logic       last;
   } rsp_type;

   // one classified item: header, bytes that follow it (low byte first), run length
   typedef struct packed {
      logic [7:0]         header;
      logic [VALUE_W-1:0] payload;
      logic [3:0]         count;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

// ===== design/pve_stream_if.sv =====
`timescale 1ns / 1ps

interface pve_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/pve_front.sv =====
`timescale 1ns / 1ps

module pve_front
   import pve_pkg::*;
(
   pve_stream_if.sink req_chan,
   input  logic       queue_full,
   output push_type   push
);

   logic [VALUE_W-1:0] code;
   logic [3:0]         nbytes;
   entry_type          entry;

   always_comb begin
      case (mode_type'(req_chan.payload.action))
         MODE_SIGNED: begin
            code = {req_chan.payload.value[VALUE_W-2:0], 1'b0}
                   ^ {VALUE_W{req_chan.payload.value[VALUE_W-1]}};
         end
         MODE_DOUBLE: begin
            for (int i = 0; i < 8; i++) begin
               code[8*i +: 8] = req_chan.payload.value[8*(7-i) +: 8];
            end
         end
         default: begin
            code = req_chan.payload.value;
         end
      endcase
   end

   always_comb begin
      nbytes = 4'd4;
      for (int i = 4; i < 8; i++) begin
         if (code[8*i +: 8] != 8'd0) begin
            nbytes = 4'(i + 1);
         end
      end
   end

   always_comb begin
      entry.payload = '0;
      if (code[VALUE_W-1:7] == '0) begin
         entry.header = code[7:0];
         entry.count  = 4'd1;
      end else if (code[VALUE_W-1:14] == '0) begin
         entry.header  = HDR_TWO | {2'b00, code[5:0]};
         entry.payload = code >> 6;
         entry.count   = 4'd2;
      end else if (code[VALUE_W-1:21] == '0) begin
         entry.header  = HDR_THREE | {3'b000, code[4:0]};
         entry.payload = code >> 5;
         entry.count   = 4'd3;
      end else if (code[VALUE_W-1:28] == '0) begin
         entry.header  = HDR_FOUR | {4'b0000, code[3:0]};
         entry.payload = code >> 4;
         entry.count   = 4'd4;
      end else begin
         entry.header  = HDR_LONG | {5'b00000, 3'(nbytes - 4'd1)};
         entry.payload = code;
         entry.count   = nbytes + 4'd1;
      end
   end

   assign req_chan.ready = !queue_full;
   assign push.valid     = req_chan.valid && !queue_full;
   assign push.entry     = entry;

endmodule

// ===== design/pve_queue.sv =====
`timescale 1ns / 1ps

module pve_queue
   import pve_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      full,
   input  logic      pop,
   output logic      avail,
   output entry_type head
);

   entry_type  mem_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_wr, do_rd;

   assign full  = fill_ff == 2'(QUEUE_DEPTH);
   assign avail = fill_ff != 2'd0;
   assign head  = mem_ff[rd_ptr_ff];
   assign do_wr = push.valid && !full;
   assign do_rd = pop && avail;

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ===== design/pve_back.sv =====
`timescale 1ns / 1ps

module pve_back
   import pve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        avail,
   input  entry_type   head,
   output logic        pop,
   pve_stream_if.source rsp_chan
);

   logic               active_ff, active_in;
   logic [7:0]         header_ff, header_in;
   logic [VALUE_W-1:0] payload_ff, payload_in;
   logic [3:0]         count_ff, count_in;
   logic [3:0]         index_ff, index_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic               out_load, emit, is_last;

   assign out_load = !out_valid_ff || rsp_chan.ready;
   assign emit     = active_ff && out_load;
   assign is_last  = index_ff == (count_ff - 4'd1);
   assign pop      = avail && (!active_ff || (emit && is_last));

   always_comb begin
      active_in    = active_ff;
      header_in    = header_ff;
      payload_in   = payload_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      out_valid_in = out_load ? emit : out_valid_ff;
      out_in       = out_ff;

      if (emit) begin
         out_in.out_byte   = (index_ff == 4'd0) ? header_ff : payload_ff[7:0];
         out_in.byte_index = index_ff;
         out_in.last       = is_last;
         index_in          = index_ff + 4'd1;
         // header goes first, payload shifts from the second byte on
         if (index_ff != 4'd0) begin
            payload_in = payload_ff >> 8;
         end
         if (is_last) begin
            active_in = 1'b0;
         end
      end

      if (pop) begin
         active_in  = 1'b1;
         header_in  = head.header;
         payload_in = head.payload;
         count_in   = head.count;
         index_in   = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         index_ff     <= 4'd0;
         count_ff     <= 4'd0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         index_ff     <= index_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      header_ff  <= header_in;
      payload_ff <= payload_in;
      out_ff     <= out_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

endmodule

// ===== design/prefix_varint_encoder.sv =====
`timescale 1ns / 1ps

// Prefix varint encoder: each request word is mapped (unsigned, zigzag signed or
// byte-swapped double) and encoded into a run of 1 to 9 bytes, one response
// transfer per byte, header byte first with last set on the final byte. The
// byte emitter in the back end sends one byte per cycle while the response
// channel is ready; a run is 1 byte for codes below 0x80 up to 9 bytes
// for codes with a nonzero top byte. The front end classifies an item in the
// cycle it is accepted and parks it in a two-entry queue, so requests keep
// flowing while the emitter works and runs follow each other without gaps.
module prefix_varint_encoder
   import pve_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   pve_stream_if.sink   req_chan,
   pve_stream_if.source rsp_chan
);

   push_type  push;
   logic      queue_full;
   logic      queue_avail;
   logic      queue_pop;
   entry_type queue_head;

   pve_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   pve_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (queue_pop),
      .avail (queue_avail),
      .head  (queue_head)
   );

   pve_back u_back (
      .clock    (clock),
      .reset    (reset),
      .avail    (queue_avail),
      .head     (queue_head),
      .pop      (queue_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== dv/tb_prefix_varint_encoder.sv =====
`timescale 1ns / 1ps

module tb_prefix_varint_encoder;
   import pve_pkg::*;

   localparam int WORDS_PER_PHASE = 95;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 24;

   // directed word; fixed_len of zero means the encoder model decides the bytes,
   // otherwise fixed_run holds the bytes in emission order, last byte at [7:0]
   typedef struct packed {
      mode_type    mode;
      logic [63:0] value;
      logic [3:0]  fixed_len;
      logic [71:0] fixed_run;
   } row_type;

   typedef struct packed {
      logic [3:0]      len;
      logic [8:0][7:0] b;
   } run_type;

   localparam int NUM_ROWS = 26;
   localparam row_type DIR_ROWS [NUM_ROWS] = '{
      '{MODE_UNSIGNED, 64'h0000_0000_0000_0000, 4'd1, 72'h00},
      '{MODE_UNSIGNED, 64'h0000_0000_0000_007F, 4'd1, 72'h7F},
      '{MODE_UNSIGNED, 64'h0000_0000_0000_0080, 4'd2, 72'h8002},
      '{MODE_UNSIGNED, 64'h0000_0000_0000_3FFF, 4'd2, 72'hBFFF},
      '{MODE_UNSIGNED, 64'h0000_0000_0000_4000, 4'd3, 72'hC00002},
      '{MODE_UNSIGNED, 64'h0000_0000_001F_FFFF, 4'd3, 72'hDFFFFF},
      '{MODE_UNSIGNED, 64'h0000_0000_0020_0000, 4'd4, 72'hE0000002},
      '{MODE_UNSIGNED, 64'h0000_0000_0FFF_FFFF, 4'd4, 72'hEFFFFFFF},
      '{MODE_UNSIGNED, 64'h0000_0000_1000_0000, 4'd5, 72'hF300000010},
      '{MODE_UNSIGNED, 64'h0000_00FF_FFFF_FFFF, 4'd6, 72'hF4FFFFFFFFFF},
      '{MODE_UNSIGNED, 64'h8000_0000_0000_0000, 4'd9, 72'hF70000000000000080},
      '{MODE_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 72'hF7FFFFFFFFFFFFFFFF},
      '{MODE_UNSIGNED, 64'h0000_FFFF_FFFF_FFFF, 4'd0, 72'h0},
      '{MODE_UNSIGNED, 64'h00FF_FFFF_FFFF_FFFF, 4'd0, 72'h0},
      '{MODE_SIGNED,   64'h0000_0000_0000_0000, 4'd1, 72'h00},
      '{MODE_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 72'h0},
      '{MODE_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF, 4'd0, 72'h0},
      '{MODE_SIGNED,   64'h8000_0000_0000_0000, 4'd0, 72'h0},
      '{MODE_SIGNED,   64'h0000_0000_0000_003F, 4'd0, 72'h0},
      '{MODE_SIGNED,   64'hFFFF_FFFF_FFFF_FFC0, 4'd0, 72'h0},
      '{MODE_DOUBLE,   64'h0000_0000_0000_0000, 4'd1, 72'h00},
      '{MODE_DOUBLE,   64'h3FF0_0000_0000_0000, 4'd0, 72'h0},
      '{MODE_DOUBLE,   64'h0123_4567_89AB_CDEF, 4'd0, 72'h0},
      '{MODE_DOUBLE,   64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 72'h0},
      '{MODE_SPARE,    64'h0000_0000_0000_0080, 4'd0, 72'h0},
      '{MODE_SPARE,    64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 72'h0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   pve_stream_if #(.payload_type(req_type)) req_if ();
   pve_stream_if #(.payload_type(rsp_type)) rsp_if ();

   prefix_varint_encoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // travels alongside the request payload so the monitor sees it at the transfer
   logic [3:0]  typed_len;
   logic [71:0] typed_run;

   rsp_type expected_bytes [$];
   int      send_idle_pct;
   int      recv_idle_pct;
   int      mismatch_count = 0;
   int      words_sent     = 0;
   int      bytes_checked  = 0;
   int      stall_cycles   = 0;
   int      len_count [16];

   // code value that the word maps to under each mode
   function automatic logic [63:0] map_word(mode_type mode, logic [63:0] w);
      logic [63:0] r;
      case (mode)
         MODE_SIGNED: r = {w[62:0], 1'b0} ^ {64{w[63]}};
         MODE_DOUBLE: begin
            for (int i = 0; i < 8; i++) r[i*8 +: 8] = w[(7-i)*8 +: 8];
         end
         default:     r = w;
      endcase
      return r;
   endfunction

   function automatic run_type encode_code(logic [63:0] code);
      run_type run;
      int      nbytes;
      run = '0;
      if (code < 64'h80) begin
         run.len  = 4'd1;
         run.b[0] = code[7:0];
      end else if (code < 64'h4000) begin
         run.len  = 4'd2;
         run.b[0] = HDR_TWO | {2'b0, code[5:0]};
         run.b[1] = code[13:6];
      end else if (code < 64'h20_0000) begin
         run.len  = 4'd3;
         run.b[0] = HDR_THREE | {3'b0, code[4:0]};
         run.b[1] = code[12:5];
         run.b[2] = code[20:13];
      end else if (code < 64'h1000_0000) begin
         run.len  = 4'd4;
         run.b[0] = HDR_FOUR | {4'b0, code[3:0]};
         run.b[1] = code[11:4];
         run.b[2] = code[19:12];
         run.b[3] = code[27:20];
      end else begin
         nbytes = 8;
         while (nbytes > 1 && code[(nbytes-1)*8 +: 8] == 8'h00) nbytes--;
         run.b[0] = HDR_LONG | {5'b0, 3'(nbytes - 1)};
         for (int i = 0; i < nbytes; i++) run.b[1+i] = code[i*8 +: 8];
         run.len = 4'(nbytes + 1);
      end
      return run;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s after %0d bytes: got 0x%0h, expected 0x%0h",
               $realtime, what, bytes_checked, got, want);
      mismatch_count++;
   endtask

   task automatic send_word(input mode_type mode, input logic [63:0] value,
                            input logic [3:0] fixed_len, input logic [71:0] fixed_run);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= {mode, value};
      typed_len      <= fixed_len;
      typed_run      <= fixed_run;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // pick a code value first, then the word that maps to it, so every mode
   // reaches every encoding form
   task automatic send_random_word();
      logic [63:0] code;
      logic [63:0] value;
      int          width;
      int          pick;
      mode_type    mode;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 7))
            0: code = 64'h80;
            1: code = 64'h4000;
            2: code = 64'h20_0000;
            3: code = 64'h1000_0000;
            4: code = 64'h1_0000_0000;
            5: code = 64'h100_0000_0000;
            6: code = 64'h1_0000_0000_0000;
            default: code = 64'h100_0000_0000_0000;
         endcase
         code = code + 64'($urandom_range(0, 2)) - 64'd1;
      end else begin
         width = $urandom_range(0, 64);
         code  = {$urandom, $urandom};
         if (width < 64) code = code & ((64'h1 << width) - 64'h1);
      end
      pick = $urandom_range(0, 9);
      if (pick < 3) mode = MODE_UNSIGNED;
      else if (pick < 6) mode = MODE_SIGNED;
      else if (pick < 9) mode = MODE_DOUBLE;
      else mode = MODE_SPARE;
      case (mode)
         MODE_SIGNED: value = (code >> 1) ^ {64{code[0]}};
         MODE_DOUBLE: begin
            for (int i = 0; i < 8; i++) value[i*8 +: 8] = code[(7-i)*8 +: 8];
         end
         default:     value = code;
      endcase
      send_word(mode, value, 4'd0, 72'h0);
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // predicts on each request transfer, checks each response transfer
   always @(posedge clock) begin
      run_type run;
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            if (typed_len != 4'd0) begin
               run = '0;
               run.len = typed_len;
               for (int k = 0; k < typed_len; k++)
                  run.b[k] = typed_run[(typed_len - 1 - k)*8 +: 8];
            end else begin
               run = encode_code(map_word(mode_type'(req_if.payload.action),
                                          req_if.payload.value));
            end
            for (int k = 0; k < run.len; k++)
               expected_bytes.push_back({run.b[k], 4'(k), (k == run.len - 1)});
            len_count[run.len]++;
            words_sent++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected byte", got.out_byte, 64'h0);
            end else begin
               want = expected_bytes.pop_front();
               if (got.out_byte != want.out_byte)
                  report_mismatch("out_byte", got.out_byte, want.out_byte);
               if (got.byte_index != want.byte_index)
                  report_mismatch("byte_index", got.byte_index, want.byte_index);
               if (got.last != want.last)
                  report_mismatch("last", got.last, want.last);
            end
            bytes_checked++;
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d bytes still expected",
                  $realtime, STALL_LIMIT, expected_bytes.size());
         $display("tb_prefix_varint_encoder: FAIL");
         $finish;
      end
   end

   initial begin
      foreach (len_count[i]) len_count[i] = 0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      typed_len      = '0;
      typed_run      = '0;
      send_idle_pct  = 35;
      recv_idle_pct  = 56;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++)
         send_word(DIR_ROWS[i].mode, DIR_ROWS[i].value,
                   DIR_ROWS[i].fixed_len, DIR_ROWS[i].fixed_run);

      // receiver-heavy gaps, then sender-heavy, then full rate
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 56 : 0;
         recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 35 : 0;
         repeat (WORDS_PER_PHASE) send_random_word();
      end
      req_if.valid <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("encoded %0d words (%0d directed) in all four mode codes, %0d bytes checked",
               words_sent, NUM_ROWS, bytes_checked);
      $display("runs by length 1..9: %0d %0d %0d %0d %0d %0d %0d %0d %0d, mismatches %0d",
               len_count[1], len_count[2], len_count[3], len_count[4], len_count[5],
               len_count[6], len_count[7], len_count[8], len_count[9], mismatch_count);
      if (mismatch_count == 0)
         $display("tb_prefix_varint_encoder: PASS");
      else
         $display("tb_prefix_varint_encoder: FAIL");
      $finish;
   end

endmodule
